### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### hw/rtl/lfs_pkg.sv
package lfs_pkg;
   localparam int MaxVerts = 16;
   localparam logic [12:0] OneQ12 = 13'd4096;
   localparam logic [14:0] OneQ14 = 15'd16384;
   localparam logic [23:0] SumMax = 24'hFFFFFF;

   localparam logic [2:0] RegLightX = 3'd0;
   localparam logic [2:0] RegLightY = 3'd1;
   localparam logic [2:0] RegLightZ = 3'd2;
   localparam logic [2:0] RegLightRed = 3'd3;
   localparam logic [2:0] RegLightGreen = 3'd4;
   localparam logic [2:0] RegLightBlue = 3'd5;
   localparam logic [2:0] RegDiffuseGain = 3'd6;
   localparam logic [2:0] RegAmbientLevel = 3'd7;

   typedef struct packed {
      logic signed [23:0] vertex_x;
      logic signed [23:0] vertex_y;
      logic signed [23:0] vertex_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic last_vertex;
   } req_type;

   typedef struct packed {
      logic [12:0] red;
      logic [12:0] green;
      logic [12:0] blue;
      logic overflow;
   } rsp_type;
endpackage

### hw/rtl/lfs_divider.sv
// Restoring divider, one quotient bit per cycle: 51-bit dividend, 26-bit divisor.
module lfs_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [50:0] dividend,
   input  logic [25:0] divisor,
   output logic done,
   output logic [50:0] quotient
);
   logic [50:0] quo_ff, quo_in;
   logic [26:0] rem_ff, rem_in;
   logic [25:0] dvs_ff, dvs_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [26:0] trial;
   logic [27:0] diff;

   always_comb begin
      trial = {rem_ff[25:0], quo_ff[50]};
      diff = {1'b0, trial} - {2'b00, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 6'd51;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[27]) begin
            rem_in = diff[26:0];
            quo_in = {quo_ff[49:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[49:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

### hw/rtl/lambert_face_shader.sv
// Channel  Ports              Payload
// req      req_valid/ready    req_data (vertex)
// rsp      rsp_valid/ready    rsp_data (face color)
// csr      csr_write_enable   csr_index, csr_write_data
// One vertex at a time. A lit vertex is accepted, then takes 3 multiply steps,
// a 26-step square root, the 51-step cosine divide, a gain step, a term step and
// an accumulate step per channel. With a zero cosine the divide is skipped. A last
// vertex adds three averaging divides, one per channel, and an output state.
// Reset is synchronous and active high. A waiting result stalls only the next
// last vertex; other vertices are taken while it waits.
`include "assert_macros.svh"
module lambert_face_shader (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lfs_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lfs_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_write_data
);
   import lfs_pkg::*;

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StMul = 4'd1;
   localparam logic [3:0] StSqrt = 4'd2;
   localparam logic [3:0] StDiv = 4'd3;
   localparam logic [3:0] StKc = 4'd4;
   localparam logic [3:0] StTerm = 4'd5;
   localparam logic [3:0] StAcc = 4'd6;
   localparam logic [3:0] StAvg = 4'd7;
   localparam logic [3:0] StAvgWait = 4'd8;
   localparam logic [3:0] StOut = 4'd9;

   logic signed [23:0] lx_ff, ly_ff, lz_ff;
   logic [12:0] lr_ff, lg_ff, lb_ff, amb_ff;
   logic [13:0] kd_ff;

   logic [3:0] st_ff, st_in;
   req_type v_ff;
   logic signed [24:0] d_ff [3];
   logic signed [15:0] n_ff [3];
   logic [1:0] ax_ff, ax_in;
   logic [51:0] l2_ff, l2_in;
   logic signed [42:0] dot_ff, dot_in;
   logic [51:0] rad_ff, rad_in;
   logic [26:0] root_ff, root_in;
   logic [27:0] srem_ff, srem_in;
   logic [4:0] sc_ff, sc_in;
   logic [14:0] cos_ff, cos_in;
   logic [27:0] kc_ff, kc_in;
   logic [1:0] ch_ff, ch_in;
   logic [23:0] sum_ff [3];
   logic [4:0] cnt_ff;
   logic many_ff;
   logic [12:0] avg_ff [3];
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic [4:0] sqrt_idx;

   logic div_start, div_done;
   logic [50:0] div_a, div_q;
   logic [25:0] div_b;

   lfs_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   assign req_ready = (st_ff == StIdle) && !(rsp_valid_ff && req_data.last_vertex);
   wire accept = req_valid && req_ready;

   // Products of one axis per cycle.
   wire signed [49:0] sq_p = d_ff[ax_ff] * d_ff[ax_ff];
   wire signed [41:0] dt_p = d_ff[ax_ff] * n_ff[ax_ff];
   logic [12:0] col;
   logic [40:0] tm_full;
   logic [23:0] acc_add;
   logic [24:0] acc_sum;

   always_comb begin
      case (ch_ff)
         2'd0: col = lr_ff;
         2'd1: col = lg_ff;
         default: col = lb_ff;
      endcase
      tm_full = 41'(kc_ff) * 41'(col);
      acc_add = 24'(tm_full >> 26) + 24'(amb_ff);
      acc_sum = {1'b0, sum_ff[ch_ff]} + {1'b0, acc_add};
   end

   // Square root: two radicand bits per cycle.
   logic [27:0] s_trial;
   always_comb begin
      sqrt_idx = sc_ff;
      s_trial = {srem_ff[25:0], rad_ff[51:50]};
   end
   wire [28:0] s_diff = {1'b0, s_trial} - {1'b0, root_ff[25:0], 2'b01};

   always_comb begin
      st_in = st_ff;
      ax_in = ax_ff;
      l2_in = l2_ff;
      dot_in = dot_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      sc_in = sc_ff;
      cos_in = cos_ff;
      kc_in = kc_ff;
      ch_in = ch_ff;
      div_start = 1'b0;
      div_a = 51'(dot_ff);
      div_b = root_ff[25:0];
      case (st_ff)
         StIdle: begin
            if (accept) begin
               ax_in = 2'd0;
               l2_in = '0;
               dot_in = '0;
               st_in = (cnt_ff == 5'(MaxVerts)) ?
                  (req_data.last_vertex ? StAvg : StIdle) : StMul;
            end
         end
         StMul: begin
            l2_in = l2_ff + 52'(sq_p);
            dot_in = dot_ff + 43'(dt_p);
            ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               st_in = StSqrt;
               sc_in = 5'd25;
               rad_in = l2_ff + 52'(sq_p);
               root_in = '0;
               srem_in = '0;
            end
         end
         StSqrt: begin
            rad_in = {rad_ff[49:0], 2'b00};
            if (!s_diff[28]) begin
               srem_in = s_diff[27:0];
               root_in = {root_ff[25:0], 1'b1};
            end else begin
               srem_in = s_trial;
               root_in = {root_ff[25:0], 1'b0};
            end
            sc_in = sqrt_idx - 5'd1;
            if (sc_ff == 5'd0) begin
               if (dot_ff > 0 && root_in != 27'd0) begin
                  st_in = StDiv;
                  div_start = 1'b1;
                  div_b = root_in[25:0];
               end else begin
                  cos_in = '0;
                  st_in = StKc;
               end
            end
         end
         StDiv: begin
            if (div_done) begin
               cos_in = (div_q > 51'(OneQ14)) ? OneQ14 : div_q[14:0];
               st_in = StKc;
            end
         end
         StKc: begin
            kc_in = 28'(kd_ff) * 28'(cos_ff);
            ch_in = 2'd0;
            st_in = StTerm;
         end
         StTerm: st_in = StAcc;
         StAcc: begin
            ch_in = ch_ff + 2'd1;
            if (ch_ff == 2'd2) begin
               ch_in = 2'd0;
               st_in = v_ff.last_vertex ? StAvg : StIdle;
            end else begin
               st_in = StAcc;
            end
         end
         StAvg: begin
            div_start = 1'b1;
            div_a = 51'(sum_ff[ch_ff]);
            div_b = 26'(cnt_ff);
            st_in = StAvgWait;
         end
         StAvgWait: begin
            div_a = 51'(sum_ff[ch_ff]);
            if (div_done) begin
               if (ch_ff == 2'd2) begin
                  ch_in = 2'd0;
                  st_in = StOut;
               end else begin
                  ch_in = ch_ff + 2'd1;
                  st_in = StAvg;
               end
            end
         end
         StOut: st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff <= req_data;
         d_ff[0] <= 25'(lx_ff) - 25'(req_data.vertex_x);
         d_ff[1] <= 25'(ly_ff) - 25'(req_data.vertex_y);
         d_ff[2] <= 25'(lz_ff) - 25'(req_data.vertex_z);
         n_ff[0] <= req_data.normal_x;
         n_ff[1] <= req_data.normal_y;
         n_ff[2] <= req_data.normal_z;
      end
      ax_ff <= ax_in;
      l2_ff <= l2_in;
      dot_ff <= dot_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      sc_ff <= sc_in;
      cos_ff <= cos_in;
      kc_ff <= kc_in;
      if (st_ff == StAvgWait && div_done)
         avg_ff[ch_ff] <= (div_q > 51'(OneQ12)) ? OneQ12 : div_q[12:0];
      if (reset) begin
         st_ff <= StIdle;
         ch_ff <= 2'd0;
         lx_ff <= 24'sd102400;
         ly_ff <= 24'sd153600;
         lz_ff <= 24'sd128000;
         lr_ff <= 13'd1229;
         lg_ff <= 13'd1229;
         lb_ff <= 13'd1229;
         kd_ff <= 14'd4096;
         amb_ff <= 13'd1229;
         sum_ff[0] <= '0;
         sum_ff[1] <= '0;
         sum_ff[2] <= '0;
         cnt_ff <= '0;
         many_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ch_ff <= ch_in;
         if (csr_write_enable) begin
            case (csr_index)
               RegLightX: lx_ff <= csr_write_data;
               RegLightY: ly_ff <= csr_write_data;
               RegLightZ: lz_ff <= csr_write_data;
               RegLightRed: lr_ff <= csr_write_data[12:0];
               RegLightGreen: lg_ff <= csr_write_data[12:0];
               RegLightBlue: lb_ff <= csr_write_data[12:0];
               RegDiffuseGain: kd_ff <= csr_write_data[13:0];
               RegAmbientLevel: amb_ff <= csr_write_data[12:0];
               default: ;
            endcase
         end
         if (accept && cnt_ff == 5'(MaxVerts))
            many_ff <= 1'b1;
         if (st_ff == StAcc) begin
            sum_ff[ch_ff] <= acc_sum[24] ? SumMax : acc_sum[23:0];
            if (ch_ff == 2'd2)
               cnt_ff <= cnt_ff + 5'd1;
         end
         if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (st_ff == StOut) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff.red <= avg_ff[0];
            rsp_ff.green <= avg_ff[1];
            rsp_ff.blue <= avg_ff[2];
            rsp_ff.overflow <= many_ff;
            sum_ff[0] <= '0;
            sum_ff[1] <= '0;
            sum_ff[2] <= '0;
            cnt_ff <= '0;
            many_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_NEVER(a_cnt_max, clock, reset, cnt_ff > 5'(MaxVerts))
   `ASSERT_CLK(a_out_stall, clock, reset, (st_ff == StOut) |-> !rsp_valid_ff)
   `ASSERT_CLK(a_ready_idle, clock, reset, req_ready |-> (st_ff == StIdle))
endmodule

### tb/sv/lambert_face_shader_checker.sv
module lambert_face_shader_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  lfs_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  lfs_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_write_data,
   output int failures,
   output int colors_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lfs_pkg::*;

   logic signed [23:0] lx, ly, lz;
   logic [12:0] col_r, col_g, col_b, amb;
   logic [13:0] kd;
   logic [23:0] acc_r, acc_g, acc_b;
   int unsigned verts;
   bit overfull;
   rsp_type face_colors[$];

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [23:0] add_clip(logic [23:0] s, longint unsigned a);
      longint unsigned r;
      r = s + a;
      return (r > SumMax) ? SumMax : r[23:0];
   endfunction

   function automatic logic [12:0] face_avg(logic [23:0] s);
      longint unsigned v;
      v = s / verts;
      return (v > OneQ12) ? OneQ12 : v[12:0];
   endfunction

   task automatic shade_vertex(req_type v);
      longint signed dx, dy, dz, dotp;
      longint unsigned len, cosv, kc;
      rsp_type c;
      if (verts >= MaxVerts) begin
         overfull = 1'b1;
      end else begin
         dx = longint'(lx) - longint'(v.vertex_x);
         dy = longint'(ly) - longint'(v.vertex_y);
         dz = longint'(lz) - longint'(v.vertex_z);
         len = int_sqrt(dx * dx + dy * dy + dz * dz);
         dotp = dx * longint'(v.normal_x) + dy * longint'(v.normal_y)
            + dz * longint'(v.normal_z);
         cosv = 0;
         if (dotp > 0 && len != 0) begin
            cosv = longint'(dotp) / len;
            if (cosv > OneQ14) cosv = OneQ14;
         end
         kc = kd * cosv;
         acc_r = add_clip(acc_r, ((kc * col_r) >> 26) + amb);
         acc_g = add_clip(acc_g, ((kc * col_g) >> 26) + amb);
         acc_b = add_clip(acc_b, ((kc * col_b) >> 26) + amb);
         verts++;
      end
      if (v.last_vertex) begin
         c.red = face_avg(acc_r);
         c.green = face_avg(acc_g);
         c.blue = face_avg(acc_b);
         c.overflow = overfull;
         face_colors.push_back(c);
         acc_r = '0;
         acc_g = '0;
         acc_b = '0;
         verts = 0;
         overfull = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         lx <= 24'sd102400; ly <= 24'sd153600; lz <= 24'sd128000;
         col_r <= 13'd1229; col_g <= 13'd1229; col_b <= 13'd1229;
         kd <= 14'd4096; amb <= 13'd1229;
         acc_r = '0; acc_g = '0; acc_b = '0;
         verts = 0; overfull = 1'b0;
         face_colors.delete();
         failures <= 0;
         colors_pending <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               RegLightX: lx <= csr_write_data;
               RegLightY: ly <= csr_write_data;
               RegLightZ: lz <= csr_write_data;
               RegLightRed: col_r <= csr_write_data[12:0];
               RegLightGreen: col_g <= csr_write_data[12:0];
               RegLightBlue: col_b <= csr_write_data[12:0];
               RegDiffuseGain: kd <= csr_write_data[13:0];
               RegAmbientLevel: amb <= csr_write_data[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) shade_vertex(req_data);
         if (rsp_valid && rsp_ready) begin
            if (face_colors.size() == 0) begin
               $error("unexpected face color item %h", rsp_data);
               errs++;
            end else begin
               want = face_colors.pop_front();
               if (rsp_data.red !== want.red) begin
                  $error("red expected %0d actual %0d", want.red, rsp_data.red);
                  errs++;
               end
               if (rsp_data.green !== want.green) begin
                  $error("green expected %0d actual %0d", want.green, rsp_data.green);
                  errs++;
               end
               if (rsp_data.blue !== want.blue) begin
                  $error("blue expected %0d actual %0d", want.blue, rsp_data.blue);
                  errs++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow expected %0d actual %0d", want.overflow,
                     rsp_data.overflow);
                  errs++;
               end
            end
         end
         failures <= failures + errs;
         colors_pending <= face_colors.size();
      end
   end
endmodule

### tb/sv/lambert_face_shader_test.sv
module lambert_face_shader_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lfs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_write_enable = 0;
   logic [2:0] csr_index = RegLightX;
   logic [23:0] csr_write_data = '0;
   int failures, colors_pending;
   int cycles = 0;
   bit long_stall = 0;
   localparam int CycleLimit = 1500000;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   lambert_face_shader DUT (.*);

   lambert_face_shader_checker checker_inst (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stall per item, with one long hold-off on request.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (long_stall) begin
            rsp_ready <= 0;
            repeat (3000) @(posedge clock);
            long_stall = 0;
         end
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock iff rsp_valid);
      end
   end

   // After each write the write enable is dropped before the task returns.
   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      wait (colors_pending == 0);
      repeat (600) @(posedge clock);
   endtask

   // Valid stays high after acceptance; drain() or the next call with a gap takes it down.
   task automatic send_vertex(req_type v, bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(2) == 0) ? 0 : $urandom_range(15));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= v;
      @(posedge clock iff req_ready);
   endtask

   function automatic req_type rand_vertex(bit last, int mode);
      req_type v;
      int a;
      v.vertex_x = 24'($urandom);
      v.vertex_y = 24'($urandom);
      v.vertex_z = 24'($urandom);
      if (mode == 0) begin
         // Near the scene, so that cosines land in a useful range.
         v.vertex_x = 24'($signed($urandom_range(65536)) - 32768);
         v.vertex_y = 24'($signed($urandom_range(65536)) - 32768);
         v.vertex_z = 24'($signed($urandom_range(65536)) - 32768);
      end
      a = $urandom_range(3);
      v.normal_x = 16'($signed($urandom_range(32768)) - 16384);
      v.normal_y = 16'($signed($urandom_range(32768)) - 16384);
      v.normal_z = 16'($signed($urandom_range(32768)) - 16384);
      if (a == 0) v.normal_x = 16'($urandom);
      v.last_vertex = last;
      return v;
   endfunction

   task automatic send_face(int nverts, int mode, bit no_gap);
      for (int i = 0; i < nverts; i++)
         send_vertex(rand_vertex(i == nverts - 1, mode), no_gap);
   endtask

   task automatic random_setting();
      write_reg(RegLightX, 24'($urandom));
      write_reg(RegLightY, 24'($urandom));
      write_reg(RegLightZ, 24'($urandom));
      write_reg(RegLightRed, 24'($urandom_range(4096)));
      write_reg(RegLightGreen, 24'($urandom_range(4096)));
      write_reg(RegLightBlue, 24'($urandom_range(4096)));
      write_reg(RegDiffuseGain, 24'($urandom_range(16383)));
      write_reg(RegAmbientLevel, 24'($urandom_range(4096)));
   endtask

   initial begin
      req_type v;
      int sent;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes of the fields at reset settings.
      v = '0;
      v.vertex_x = 24'sh7FFFFF; v.vertex_y = 24'sh800000; v.vertex_z = 24'sh7FFFFF;
      v.normal_x = 16'sh4000; v.normal_y = -16'sh4000; v.normal_z = 16'sh4000;
      send_vertex(v, 0);
      v.normal_x = 16'sh7FFF; v.normal_y = 16'sh8000; v.normal_z = 16'shFFFF;
      v.last_vertex = 1;
      send_vertex(v, 0);
      // Vertex at the light: zero-length vector.
      v = '0;
      v.vertex_x = 24'sd102400; v.vertex_y = 24'sd153600; v.vertex_z = 24'sd128000;
      v.normal_x = 16'sd16384; v.last_vertex = 1;
      send_vertex(v, 0);
      // Normal far from unit length pushes the cosine above one.
      v = '0;
      v.normal_x = 16'sh7FFF; v.normal_y = 16'sh7FFF; v.normal_z = 16'sh7FFF;
      v.last_vertex = 1;
      send_vertex(v, 0);
      // Face with too many vertices.
      send_face(MaxVerts + 2, 0, 0);
      send_face(MaxVerts, 0, 0);
      drain();

      // Extreme settings: bright light, maximum gain, full ambient.
      write_reg(RegLightX, 24'h7FFFFF);
      write_reg(RegLightY, 24'h800000);
      write_reg(RegLightZ, 24'h000000);
      write_reg(RegLightRed, 24'h001FFF);
      write_reg(RegLightGreen, 24'd4096);
      write_reg(RegLightBlue, 24'd0);
      write_reg(RegDiffuseGain, 24'h003FFF);
      write_reg(RegAmbientLevel, 24'h001FFF);
      send_face(3, 1, 0);
      send_face(1, 0, 0);
      drain();
      write_reg(RegLightX, 24'd0);
      write_reg(RegLightY, 24'd0);
      write_reg(RegLightZ, 24'd0);
      write_reg(RegDiffuseGain, 24'd0);
      write_reg(RegAmbientLevel, 24'd0);
      send_face(2, 0, 0);
      drain();
      write_reg(RegLightX, 24'd5000);
      write_reg(RegDiffuseGain, 24'd16383);
      write_reg(RegLightRed, 24'd4096);
      write_reg(RegLightBlue, 24'd4096);
      write_reg(RegLightGreen, 24'd2000);
      write_reg(RegAmbientLevel, 24'd300);

      // Long receiver hold-off while vertices keep coming.
      long_stall = 1;
      for (int i = 0; i < 8; i++) send_face(2, 0, 1);
      drain();

      sent = 0;
      while (sent < 950) begin
         int n;
         if (sent % 200 == 0) begin
            drain();
            random_setting();
         end
         n = ($urandom_range(15) == 0) ? $urandom_range(MaxVerts + 4, 1)
            : $urandom_range(6, 1);
         send_face(n, ($urandom_range(4) == 0), ($urandom_range(7) == 0));
         sent += n;
      end
      drain();
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
